// ===== src/msgd_pkg.sv =====
package msgd_pkg;

  localparam int RANK      = 16;
  localparam int NUM_USERS = 4096;
  localparam int NUM_ITEMS = 4096;

  localparam int JW       = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int CW       = $clog2(RANK + 1);
  localparam int ROW_W    = 12;
  localparam int ADDR_W   = ROW_W + JW;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int ACC_W    = 56;

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

  typedef enum logic [2:0] {
    CMD_WR_USER = 3'd0,
    CMD_WR_ITEM = 3'd1,
    CMD_TRAIN   = 3'd2,
    CMD_RD_USER = 3'd3,
    CMD_RD_ITEM = 3'd4,
    CMD_EPOCH   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_INIT_RATE = 2'd0,
    REG_DECAY     = 2'd1,
    REG_NB_SQ     = 2'd2,
    REG_NB        = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_RD_WAIT,
    S_EPOCH,
    S_LOAD,
    S_DOT_I,
    S_DOT_A,
    S_ERR,
    S_STEP_I,
    S_STEP_A,
    S_UPD_I,
    S_UPD_A1,
    S_UPD_A2,
    S_SQ_I,
    S_SQ_A,
    S_CMP,
    S_SQRT,
    S_PRJ_I,
    S_PRJ_S,
    S_PRJ_W,
    S_ROW_END,
    S_WB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [11:0]        user_index;
    logic [11:0]        item_index;
    logic signed [31:0] rating;
    logic [3:0]         factor_index;
    logic signed [31:0] factor_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic signed [31:0] error;
    logic               user_projected;
    logic               item_projected;
  } out_item_t;

  typedef struct packed {
    logic        busy;
    logic        ovf;
    logic [31:0] quo;
  } div_res_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] root;
  } sqrt_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/maxnorm_factor_sgd_step_unit.sv =====
// Train: each rescaled row adds the square root and, per factor, the bit-serial divider.
// Throughput: one command at a time; in_stall is high until the result is taken.
// Reset (synchronous, rst_n low): FSM to idle, configuration registers to defaults, rate to 655.
// Factor tables are not cleared and must be written before use.
module maxnorm_factor_sgd_step_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msgd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msgd_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  msgd_pkg::state_t    state_r, state_nxt;
  msgd_pkg::in_item_t  req_r, req_nxt;
  msgd_pkg::out_item_t out_r, out_nxt;

  logic [msgd_pkg::CW-1:0]           cnt_r, cnt_nxt;
  logic signed [msgd_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0]                err_r, err_nxt;
  logic signed [31:0]                step_r, step_nxt;
  logic [31:0]                       norm_r, norm_nxt;
  logic                              prow_r, prow_nxt;
  logic                              uproj_r, uproj_nxt;
  logic                              iproj_r, iproj_nxt;
  logic [31:0]                       rate_r;

  logic [16:0] init_rate_r;
  logic [16:0] decay_r;
  logic [30:0] nbsq_r;
  logic [30:0] nb_r;

  logic signed [31:0] u_r  [msgd_pkg::RANK];
  logic signed [31:0] v_r  [msgd_pkg::RANK];
  logic signed [31:0] nu_r [msgd_pkg::RANK];
  logic signed [31:0] nv_r [msgd_pkg::RANK];

  logic [31:0] umem [msgd_pkg::MEM_DEPTH];
  logic [31:0] vmem [msgd_pkg::MEM_DEPTH];
  logic [31:0] umem_q_r, vmem_q_r;
  logic [msgd_pkg::ADDR_W-1:0] umem_wa, vmem_wa, umem_ra, vmem_ra;
  logic [31:0] umem_wd, vmem_wd;
  logic        umem_we, vmem_we;

  logic [msgd_pkg::JW-1:0] j, jm1, fcol, rcol;
  logic                    last;
  logic signed [31:0]      x_cur;
  logic [32:0]             mag;
  logic                    ok_u, ok_v, ok_f;
  logic [47:0]             sq_sat;
  logic [31:0]             ep_rate;
  logic                    rate_we;
  logic                    ld_en;
  logic                    nu_we, nv_we;
  logic signed [31:0]      nu_val, nv_val, pv;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic               div_start, sqrt_start;
  msgd_pkg::div_res_t  div_res;
  msgd_pkg::sqrt_res_t sqrt_res;
  logic [63:0]        sqrt_in;
  logic               cfg_wr;

  msgd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  msgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[63:0]),
    .divisor  (norm_r),
    .res      (div_res)
  );

  msgd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .res      (sqrt_res)
  );

  assign j      = cnt_r[msgd_pkg::JW-1:0];
  assign jm1    = msgd_pkg::JW'(cnt_r - msgd_pkg::CW'(1));
  assign last   = (cnt_r == msgd_pkg::CW'(msgd_pkg::RANK - 1));
  assign fcol   = msgd_pkg::JW'(req_r.factor_index);
  assign x_cur  = prow_r ? nv_r[j] : nu_r[j];
  assign mag    = x_cur[31] ? (33'd0 - {x_cur[31], x_cur}) : {1'b0, x_cur};
  assign ok_u   = 32'(req_r.user_index) < msgd_pkg::NUM_USERS;
  assign ok_v   = 32'(req_r.item_index) < msgd_pkg::NUM_ITEMS;
  assign ok_f   = 32'(req_r.factor_index) < msgd_pkg::RANK;
  assign sq_sat = (acc_r[msgd_pkg::ACC_W-1:48] != '0) ? '1 : acc_r[47:0];
  assign sqrt_in = {sq_sat, 16'd0};
  assign ep_rate = (mul_p[65:48] != '0) ? '1 : mul_p[47:16];

  // ---------------- configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (msgd_pkg::reg_idx_t'(paddr[3:2]))
      msgd_pkg::REG_INIT_RATE: prdata = 32'(init_rate_r);
      msgd_pkg::REG_DECAY:     prdata = 32'(decay_r);
      msgd_pkg::REG_NB_SQ:     prdata = 32'(nbsq_r);
      msgd_pkg::REG_NB:        prdata = 32'(nb_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_rate_r <= 17'd655;
      decay_r     <= 17'd65536;
      nbsq_r      <= 31'd65536;
      nb_r        <= 31'd65536;
      rate_r      <= 32'd655;
    end else begin
      if (cfg_wr) begin
        unique case (msgd_pkg::reg_idx_t'(paddr[3:2]))
          msgd_pkg::REG_INIT_RATE: begin
            init_rate_r <= pwdata[16:0];
            rate_r      <= 32'(pwdata[16:0]);
          end
          msgd_pkg::REG_DECAY: decay_r <= pwdata[16:0];
          msgd_pkg::REG_NB_SQ: nbsq_r  <= pwdata[30:0];
          msgd_pkg::REG_NB:    nb_r    <= pwdata[30:0];
          default: ;
        endcase
      end else if (rate_we) begin
        rate_r <= ep_rate;
      end
    end
  end

  // ---------------- factor tables
  assign rcol    = (state_r == msgd_pkg::S_LOAD) ? j : fcol;
  assign umem_ra = {req_r.user_index, rcol};
  assign vmem_ra = {req_r.item_index, rcol};
  assign umem_wa = {req_r.user_index, (state_r == msgd_pkg::S_WB) ? j : fcol};
  assign vmem_wa = {req_r.item_index, (state_r == msgd_pkg::S_WB) ? j : fcol};
  assign umem_wd = (state_r == msgd_pkg::S_WB) ? nu_r[j] : req_r.factor_value;
  assign vmem_wd = (state_r == msgd_pkg::S_WB) ? nv_r[j] : req_r.factor_value;

  always_ff @(posedge clk) begin
    if (umem_we) begin
      umem[umem_wa] <= umem_wd;
    end
    umem_q_r <= umem[umem_ra];
  end

  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_wa] <= vmem_wd;
    end
    vmem_q_r <= vmem[vmem_ra];
  end

  // ---------------- row buffers
  always_ff @(posedge clk) begin
    if (ld_en) begin
      u_r[jm1] <= umem_q_r;
      v_r[jm1] <= vmem_q_r;
    end
    if (nu_we) begin
      nu_r[j] <= nu_val;
    end
    if (nv_we) begin
      nv_r[j] <= nv_val;
    end
  end

  // rescaled factor, saturated with the sign restored
  always_comb begin
    if (div_res.ovf) begin
      pv = x_cur[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (x_cur[31]) begin
      pv = div_res.quo[31] ? 32'sh80000000 : (32'sd0 - div_res.quo);
    end else begin
      pv = div_res.quo[31] ? 32'sh7FFFFFFF : div_res.quo;
    end
  end

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msgd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    out_r   <= out_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    err_r   <= err_nxt;
    step_r  <= step_nxt;
    norm_r  <= norm_nxt;
    prow_r  <= prow_nxt;
    uproj_r <= uproj_nxt;
    iproj_r <= iproj_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    out_nxt    = out_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    step_nxt   = step_r;
    norm_nxt   = norm_r;
    prow_nxt   = prow_r;
    uproj_nxt  = uproj_r;
    iproj_nxt  = iproj_r;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    rate_we    = 1'b0;
    ld_en      = 1'b0;
    nu_we      = 1'b0;
    nv_we      = 1'b0;
    nu_val     = '0;
    nv_val     = '0;
    umem_we    = 1'b0;
    vmem_we    = 1'b0;

    unique case (state_r)
      msgd_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = msgd_pkg::S_DISP;
        end
      end

      msgd_pkg::S_DISP: begin
        out_nxt   = '0;
        err_nxt   = '0;
        state_nxt = msgd_pkg::S_OUT;
        mul_a     = {1'b0, rate_r};
        mul_b     = {16'd0, decay_r};
        unique case (msgd_pkg::cmd_t'(req_r.cmd))
          msgd_pkg::CMD_WR_USER: umem_we = ok_u && ok_f;
          msgd_pkg::CMD_WR_ITEM: vmem_we = ok_v && ok_f;
          msgd_pkg::CMD_RD_USER: begin
            if (ok_u && ok_f) begin
              state_nxt = msgd_pkg::S_RD_WAIT;
            end
          end
          msgd_pkg::CMD_RD_ITEM: begin
            if (ok_v && ok_f) begin
              state_nxt = msgd_pkg::S_RD_WAIT;
            end
          end
          msgd_pkg::CMD_TRAIN: begin
            if (ok_u && ok_v) begin
              cnt_nxt   = '0;
              prow_nxt  = 1'b0;
              uproj_nxt = 1'b0;
              iproj_nxt = 1'b0;
              state_nxt = msgd_pkg::S_LOAD;
            end
          end
          msgd_pkg::CMD_EPOCH: state_nxt = msgd_pkg::S_EPOCH;
          default: ;
        endcase
      end

      msgd_pkg::S_RD_WAIT: begin
        out_nxt.read_value = (req_r.cmd == msgd_pkg::CMD_RD_USER) ? umem_q_r : vmem_q_r;
        state_nxt          = msgd_pkg::S_OUT;
      end

      msgd_pkg::S_EPOCH: begin
        rate_we   = 1'b1;
        state_nxt = msgd_pkg::S_OUT;
      end

      // read address runs one ahead of the buffer write
      msgd_pkg::S_LOAD: begin
        ld_en   = (cnt_r != '0);
        cnt_nxt = cnt_r + msgd_pkg::CW'(1);
        if (cnt_r == msgd_pkg::CW'(msgd_pkg::RANK)) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = msgd_pkg::S_DOT_I;
        end
      end

      msgd_pkg::S_DOT_I: begin
        mul_a     = 33'(u_r[j]);
        mul_b     = 33'(v_r[j]);
        state_nxt = msgd_pkg::S_DOT_A;
      end

      msgd_pkg::S_DOT_A: begin
        acc_nxt = acc_r + msgd_pkg::ACC_W'(mul_p >>> 16);
        cnt_nxt = cnt_r + msgd_pkg::CW'(1);
        state_nxt = msgd_pkg::S_DOT_I;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = msgd_pkg::S_ERR;
        end
      end

      msgd_pkg::S_ERR: begin
        err_nxt   = msgd_pkg::sat32(68'(acc_r) - 68'(req_r.rating));
        state_nxt = msgd_pkg::S_STEP_I;
      end

      msgd_pkg::S_STEP_I: begin
        mul_a     = {1'b0, rate_r};
        mul_b     = 33'(err_r);
        state_nxt = msgd_pkg::S_STEP_A;
      end

      msgd_pkg::S_STEP_A: begin
        step_nxt  = msgd_pkg::sat32(68'(mul_p >>> 16));
        state_nxt = msgd_pkg::S_UPD_I;
      end

      msgd_pkg::S_UPD_I: begin
        mul_a     = 33'(step_r);
        mul_b     = 33'(v_r[j]);
        state_nxt = msgd_pkg::S_UPD_A1;
      end

      // consume step*v, issue step*u
      msgd_pkg::S_UPD_A1: begin
        nu_we     = 1'b1;
        nu_val    = msgd_pkg::sat32(68'(u_r[j]) - 68'(mul_p >>> 16));
        mul_a     = 33'(step_r);
        mul_b     = 33'(u_r[j]);
        state_nxt = msgd_pkg::S_UPD_A2;
      end

      msgd_pkg::S_UPD_A2: begin
        nv_we     = 1'b1;
        nv_val    = msgd_pkg::sat32(68'(v_r[j]) - 68'(mul_p >>> 16));
        cnt_nxt   = cnt_r + msgd_pkg::CW'(1);
        state_nxt = msgd_pkg::S_UPD_I;
        if (last) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = msgd_pkg::S_SQ_I;
        end
      end

      msgd_pkg::S_SQ_I: begin
        mul_a     = 33'(x_cur);
        mul_b     = 33'(x_cur);
        state_nxt = msgd_pkg::S_SQ_A;
      end

      msgd_pkg::S_SQ_A: begin
        acc_nxt   = acc_r + msgd_pkg::ACC_W'(mul_p >>> 16);
        cnt_nxt   = cnt_r + msgd_pkg::CW'(1);
        state_nxt = msgd_pkg::S_SQ_I;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = msgd_pkg::S_CMP;
        end
      end

      msgd_pkg::S_CMP: begin
        if (sq_sat >= 48'(nbsq_r)) begin
          sqrt_start = 1'b1;
          state_nxt  = msgd_pkg::S_SQRT;
        end else begin
          state_nxt = msgd_pkg::S_ROW_END;
        end
      end

      msgd_pkg::S_SQRT: begin
        if (!sqrt_res.busy) begin
          norm_nxt  = sqrt_res.root;
          cnt_nxt   = '0;
          state_nxt = (sqrt_res.root == '0) ? msgd_pkg::S_ROW_END : msgd_pkg::S_PRJ_I;
        end
      end

      msgd_pkg::S_PRJ_I: begin
        mul_a     = mag;
        mul_b     = {2'b00, nb_r};
        state_nxt = msgd_pkg::S_PRJ_S;
      end

      msgd_pkg::S_PRJ_S: begin
        div_start = 1'b1;
        state_nxt = msgd_pkg::S_PRJ_W;
      end

      msgd_pkg::S_PRJ_W: begin
        if (!div_res.busy) begin
          nu_we   = !prow_r;
          nv_we   = prow_r;
          nu_val  = pv;
          nv_val  = pv;
          cnt_nxt = cnt_r + msgd_pkg::CW'(1);
          state_nxt = msgd_pkg::S_PRJ_I;
          if (last) begin
            if (prow_r) begin
              iproj_nxt = 1'b1;
            end else begin
              uproj_nxt = 1'b1;
            end
            state_nxt = msgd_pkg::S_ROW_END;
          end
        end
      end

      msgd_pkg::S_ROW_END: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        if (prow_r) begin
          state_nxt = msgd_pkg::S_WB;
        end else begin
          prow_nxt  = 1'b1;
          state_nxt = msgd_pkg::S_SQ_I;
        end
      end

      msgd_pkg::S_WB: begin
        umem_we   = 1'b1;
        vmem_we   = 1'b1;
        cnt_nxt   = cnt_r + msgd_pkg::CW'(1);
        if (last) begin
          out_nxt.read_value     = '0;
          out_nxt.error          = err_r;
          out_nxt.user_projected = uproj_r;
          out_nxt.item_projected = iproj_r;
          state_nxt              = msgd_pkg::S_OUT;
        end
      end

      msgd_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = msgd_pkg::S_IDLE;
        end
      end

      default: state_nxt = msgd_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != msgd_pkg::S_IDLE);
  assign out_valid = (state_r == msgd_pkg::S_OUT);
  assign out_data  = out_r;

  // ---------------- checks
  a_tbl_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (umem_we || vmem_we) |-> (state_r == msgd_pkg::S_WB || state_r == msgd_pkg::S_DISP))
    else $error("factor table written outside write command or write-back");

  a_err_train: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error != '0) |-> (req_r.cmd == msgd_pkg::CMD_TRAIN))
    else $error("nonzero error on a non-train command");

  a_rd_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_value != '0) |->
      (req_r.cmd == msgd_pkg::CMD_RD_USER || req_r.cmd == msgd_pkg::CMD_RD_ITEM))
    else $error("read value on a non-read command");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (div_start || sqrt_start) |-> (!div_res.busy && !sqrt_res.busy))
    else $error("iterative unit restarted while busy");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (state_r == msgd_pkg::S_IDLE))
    else $error("sequencer did not return to idle after result transaction");

endmodule

// ===== src/msgd_mul.sv =====
module msgd_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  logic signed [65:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== src/msgd_div.sv =====
module msgd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  output msgd_pkg::div_res_t  res
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] dvd_r;
  logic [31:0] dvs_r;
  logic        ovf_r;
  logic [32:0] sh;

  // one quotient bit per cycle, restoring
  assign sh = {rem_r[31:0], dvd_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[63:32]};
      dvd_r <= dividend[31:0];
      dvs_r <= divisor;
      ovf_r <= (dividend[63:32] >= divisor);
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_r <= sh - {1'b0, dvs_r};
        dvd_r <= {dvd_r[30:0], 1'b1};
      end else begin
        rem_r <= sh;
        dvd_r <= {dvd_r[30:0], 1'b0};
      end
    end
  end

  assign res.busy = busy_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = dvd_r;

endmodule

// ===== src/msgd_isqrt.sv =====
module msgd_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         radicand,
  output msgd_pkg::sqrt_res_t res
);

  logic        busy_r;
  logic [63:0] n_r;
  logic [63:0] root_r;
  logic [63:0] bit_r;
  logic [63:0] sum;

  assign sum = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r == 64'd1) begin
      busy_r <= 1'b0;
    end
  end

  // digit-by-digit root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      root_r <= '0;
      bit_r  <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (n_r >= sum) begin
        n_r    <= n_r - sum;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign res.busy = busy_r;
  assign res.root = root_r[31:0];

endmodule
